// ----- sv/lpfr_pkg.sv -----
// lpfr_pkg: shared constants, codes and types for the length-prefixed frame reverser
package lpfr_pkg;

	localparam int BUFFER_DEPTH = 16384;
	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int LEN_W = 15;
	localparam int BYTE_W = 8;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 15'd16000;

	typedef logic [2:0] status_t;
	typedef logic [1:0] phase_t;

	localparam status_t ST_TAKEN = 3'd0;
	localparam status_t ST_GIVEN = 3'd1;
	localparam status_t ST_CLOSED = 3'd2;
	localparam status_t ST_BUSY = 3'd3;
	localparam status_t ST_EMPTY = 3'd4;

	localparam phase_t PH_HEADER = 2'd0;
	localparam phase_t PH_PAYLOAD = 2'd1;
	localparam phase_t PH_REPLY = 2'd2;
	localparam phase_t PH_CLOSED = 2'd3;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_PULL = 1'b1;

endpackage

// ----- sv/lpfr_ram.sv -----
// lpfr_ram: generic single-port ram with registered read
module lpfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- sv/length_prefixed_frame_reverser.sv -----
// length_prefixed_frame_reverser: frame store and reversed reply, top level
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid, in_ready, kind, in_byte      | request in
//  out     | out_valid, out_ready, status,          | request out
//          | out_byte, out_last                     |
//  cfg     | cfg_valid, cfg_ready, cfg_data         | write in
//
// one request per cycle sustained while out_ready holds; a taken request passes through
// the middle stage (state update and ram access), then the result register
// the payload ram has one port, used by either a byte write or a reply read
// reset clears all control state; ram contents are not cleared, no sweep needed
// a stalled result holds the middle stage, and in_ready drops once both are full
module length_prefixed_frame_reverser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    kind,
	input  logic [7:0]              in_byte,
	output logic                    out_valid,
	input  logic                    out_ready,
	output lpfr_pkg::status_t       status,
	output logic [7:0]              out_byte,
	output logic                    out_last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [14:0]             cfg_data
);

	import lpfr_pkg::*;

	logic [LEN_W-1:0] max_len_q;
	phase_t           phase_q, phase_d;
	logic [1:0]       header_count_q, header_count_d;
	logic [31:0]      frame_length_q, frame_length_d;
	logic [LEN_W-1:0] received_count_q, received_count_d;
	logic [LEN_W-1:0] reply_position_q, reply_position_d;

	logic              valid_s1;
	status_t           status_s1, status_c;
	logic [BYTE_W-1:0] hdr_byte_s1, hdr_byte_c;
	logic              use_mem_s1, use_mem_c;
	logic              last_s1, last_c;

	logic              out_valid_q;
	status_t           status_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              accept;
	logic              advance;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [BYTE_W-1:0] mem_rdata;

	logic [31:0]      hdr_len;
	logic             hdr_bad;
	logic [LEN_W-1:0] rd_idx;
	logic [LEN_W:0]   rc_next;
	logic [LEN_W:0]   last_pos;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign hdr_len = {frame_length_q[23:0], in_byte};
	assign hdr_bad = (hdr_len == 32'd0) || (hdr_len > {17'd0, max_len_q})
		|| (hdr_len > 32'(BUFFER_DEPTH));
	// reversed payload index: length - 1 - (position - 4)
	assign rd_idx   = frame_length_q[LEN_W-1:0] + 15'd3 - reply_position_q;
	assign rc_next  = {1'b0, received_count_q} + 16'd1;
	assign last_pos = {1'b0, frame_length_q[LEN_W-1:0]} + 16'd3;

	always_comb begin
		phase_d          = phase_q;
		header_count_d   = header_count_q;
		frame_length_d   = frame_length_q;
		received_count_d = received_count_q;
		reply_position_d = reply_position_q;
		status_c         = ST_TAKEN;
		hdr_byte_c       = '0;
		use_mem_c        = 1'b0;
		last_c           = 1'b0;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		mem_addr         = received_count_q[ADDR_W-1:0];
		if (accept) begin
			if (phase_q == PH_CLOSED) begin
				status_c = ST_CLOSED;
			end else if (kind == KIND_BYTE) begin
				unique case (phase_q)
					PH_REPLY: begin
						status_c = ST_BUSY;
					end
					PH_HEADER: begin
						frame_length_d = hdr_len;
						header_count_d = header_count_q + 2'd1;
						if (header_count_q == 2'd3) begin
							if (hdr_bad) begin
								phase_d  = PH_CLOSED;
								status_c = ST_CLOSED;
							end else begin
								received_count_d = '0;
								phase_d          = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						mem_we           = 1'b1;
						received_count_d = rc_next[LEN_W-1:0];
						if (rc_next >= {1'b0, frame_length_q[LEN_W-1:0]}) begin
							phase_d          = PH_REPLY;
							reply_position_d = '0;
						end
					end
					default: begin
						status_c = ST_CLOSED;
					end
				endcase
			end else if (phase_q != PH_REPLY) begin
				status_c = ST_EMPTY;
			end else begin
				status_c         = ST_GIVEN;
				reply_position_d = reply_position_q + 15'd1;
				if (reply_position_q < 15'd4) begin
					case (reply_position_q[1:0])
						2'd0:    hdr_byte_c = frame_length_q[31:24];
						2'd1:    hdr_byte_c = frame_length_q[23:16];
						2'd2:    hdr_byte_c = frame_length_q[15:8];
						default: hdr_byte_c = frame_length_q[7:0];
					endcase
				end else begin
					use_mem_c = 1'b1;
					mem_re    = 1'b1;
					mem_addr  = rd_idx[ADDR_W-1:0];
					if ({1'b0, reply_position_q} == last_pos) begin
						last_c           = 1'b1;
						phase_d          = PH_HEADER;
						header_count_d   = '0;
						frame_length_d   = '0;
						received_count_d = '0;
						reply_position_d = '0;
					end
				end
			end
		end
	end

	lpfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(in_byte),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q        <= MAX_LEN_RESET;
			phase_q          <= PH_HEADER;
			header_count_q   <= '0;
			frame_length_q   <= '0;
			received_count_q <= '0;
			reply_position_q <= '0;
			valid_s1         <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			phase_q          <= phase_d;
			header_count_q   <= header_count_d;
			frame_length_q   <= frame_length_d;
			received_count_q <= received_count_d;
			reply_position_q <= reply_position_d;
			if (in_ready) begin
				valid_s1 <= accept;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= status_c;
			hdr_byte_s1 <= hdr_byte_c;
			use_mem_s1  <= use_mem_c;
			last_s1     <= last_c;
		end
		// ram data stays put until the next read, so a stalled middle stage is safe
		if (advance && valid_s1) begin
			status_q   <= status_s1;
			out_byte_q <= use_mem_s1 ? mem_rdata : hdr_byte_s1;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_last_only_given: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |-> (status == ST_GIVEN))
		else $error("last flag on a result that carries no reply byte");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_GIVEN) |-> (out_byte == 8'd0))
		else $error("nonzero byte on a result without reply data");

	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CLOSED) |=> (phase_q == PH_CLOSED))
		else $error("block left the closed phase without reset");

	a_payload_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |->
		(frame_length_q[31:LEN_W] == '0
			&& received_count_q < frame_length_q[LEN_W-1:0]))
		else $error("payload count ran past the frame length");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(status_s1) && $stable(last_s1)))
		else $error("middle stage lost its request during a stall");

endmodule
